FILE: hw/rtl/gpeh_pkg.sv
// Shared types and GF(2^64) arithmetic for the polynomial evaluation hash.
package gpeh_pkg;

  localparam int unsigned GfWidth = 64;

  // One message block as it travels from the input register to the core.
  typedef struct packed {
    logic [GfWidth-1:0] block;
    logic               last;
  } item_t;

  // Status the core reports to the top level.
  typedef struct packed {
    logic fire;
    logic last;
    logic mid;
  } core_status_t;

  // Product of two field elements modulo x^64 + x^4 + x^3 + x + 1.
  function automatic logic [GfWidth-1:0] gf_mul(input logic [GfWidth-1:0] a,
                                                input logic [GfWidth-1:0] b);
    logic [2*GfWidth-2:0] prod;
    logic [GfWidth-2:0]   high;
    logic [GfWidth+2:0]   fold;
    logic [2:0]           top;
    int                   j;
    prod = '0;
    for (j = 0; j < GfWidth; j++) begin
      if (b[j]) begin
        prod = prod ^ ({{(GfWidth-1){1'b0}}, a} << j);
      end
    end
    // Fold the upper half back with x^64 = x^4 + x^3 + x + 1; the three bits
    // that spill past bit 63 are folded a second time.
    high = prod[2*GfWidth-2:GfWidth];
    fold = {3'b0, prod[GfWidth-1:0]} ^ {4'b0, high} ^ {3'b0, high, 1'b0}
         ^ {1'b0, high, 3'b0} ^ {high, 4'b0};
    top  = fold[GfWidth+2:GfWidth];
    gf_mul = fold[GfWidth-1:0] ^ {{(GfWidth-3){1'b0}}, top}
           ^ {{(GfWidth-4){1'b0}}, top, 1'b0} ^ {{(GfWidth-6){1'b0}}, top, 3'b0}
           ^ {{(GfWidth-7){1'b0}}, top, 4'b0};
  endfunction

endpackage

FILE: hw/rtl/gpeh_in_stage.sv
// Input register that captures one message block per transaction.
module gpeh_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gpeh_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output gpeh_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  logic            accept;
  gpeh_pkg::item_t item_q;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/gpeh_core.sv
// Hash state, the two field multipliers and the result register.
module gpeh_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  gpeh_pkg::item_t               item_i,
  output logic                          advance_o,
  input  logic [gpeh_pkg::GfWidth-1:0]  key_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gpeh_pkg::GfWidth-1:0]  hash_o,
  output gpeh_pkg::core_status_t        status_o
);

  logic [gpeh_pkg::GfWidth-1:0] sum_q, sum_d;
  logic [gpeh_pkg::GfWidth-1:0] power_q, power_d;
  logic                         mid_q, mid_d;
  logic                         out_valid_q, out_valid_d;
  logic [gpeh_pkg::GfWidth-1:0] hash_q;
  logic [gpeh_pkg::GfWidth-1:0] power_cur, sum_cur, sum_new;
  logic                         out_free, fire;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign fire      = valid_i && out_free;
  assign advance_o = fire;

  // A new message starts from the key itself and an empty sum.
  assign power_cur = mid_q ? power_q : key_i;
  assign sum_cur   = mid_q ? sum_q : '0;
  assign sum_new   = sum_cur ^ gpeh_pkg::gf_mul(item_i.block, power_cur);

  always_comb begin
    sum_d       = sum_q;
    power_d     = power_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      if (item_i.last) begin
        sum_d       = '0;
        power_d     = '0;
        mid_d       = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        sum_d   = sum_new;
        power_d = gpeh_pkg::gf_mul(power_cur, key_i);
        mid_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      power_q     <= '0;
      mid_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      power_q     <= power_d;
      mid_q       <= mid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && item_i.last) begin
      hash_q <= sum_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hash_o        = hash_q;
  assign status_o.fire = fire;
  assign status_o.last = item_i.last;
  assign status_o.mid  = mid_q;

endmodule

FILE: hw/rtl/gf2_64_polynomial_eval_hash.sv
// Polynomial evaluation hash over GF(2^64) with modulus x^64 + x^4 + x^3 + x + 1.
// A final block is held in the input register, then its hash in the result register.
// Throughput: one block per cycle if unstalled; the core multipliers set the cycle time.
// The output register frees as its transaction completes, so blocks keep flowing.
// Reset clears the key to zero and the hash state so the next block starts a message.
module gf2_64_polynomial_eval_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gpeh_pkg::GfWidth-1:0] message_block_i,
  input  logic                         final_block_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gpeh_pkg::GfWidth-1:0] hash_value_o,
  input  logic                         hash_key_we_i,
  input  logic [gpeh_pkg::GfWidth-1:0] hash_key_i
);

  logic [gpeh_pkg::GfWidth-1:0] key_q;
  gpeh_pkg::item_t              in_item, s1_item;
  logic                         s1_valid, advance;
  gpeh_pkg::core_status_t       status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (hash_key_we_i) begin
      key_q <= hash_key_i;
    end
  end

  assign in_item.block = message_block_i;
  assign in_item.last  = final_block_i;

  gpeh_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  gpeh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .advance_o   (advance),
    .key_i       (key_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_o      (hash_value_o),
    .status_o    (status)
  );

  // A final block always leaves a result behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire && status.last |=> out_valid_o)
    else $error("final block did not produce a hash");

  // A result only appears after a final block was processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(status.fire && status.last))
    else $error("hash appeared without a final block");

  // The message flag follows the last bit of each processed block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire |=> (status.mid == !$past(status.last)))
    else $error("message state out of step with processed blocks");

endmodule

FILE: verif/gf2_64_polynomial_eval_hash_tb.sv
// Self-checking testbench for the GF(2^64) polynomial evaluation hash.
module gf2_64_polynomial_eval_hash_tb;

  localparam int unsigned GfWidth = gpeh_pkg::GfWidth;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandomBlocks = 1350;
  localparam int unsigned SubPhases = 9;
  localparam logic [GfWidth-1:0] ReduceLow = 64'h1B;
  localparam logic [GfWidth-1:0] AllOnes = '1;
  localparam logic [GfWidth-1:0] TopBit = 64'h8000_0000_0000_0000;

  class hash_scoreboard;
    logic [GfWidth-1:0] key;
    logic [GfWidth-1:0] acc;
    logic [GfWidth-1:0] power;
    bit                 in_message;
    logic [GfWidth-1:0] expected_hashes[$];
    int unsigned        errors;
    int unsigned        blocks_seen;
    int unsigned        messages_seen;
    int unsigned        hashes_checked;
    int unsigned        key_writes;

    function new();
      key = '0;
      acc = '0;
      power = '0;
      in_message = 1'b0;
      errors = 0;
      blocks_seen = 0;
      messages_seen = 0;
      hashes_checked = 0;
      key_writes = 0;
    endfunction

    // Shift-and-add product; each shift folds x^64 back as x^4 + x^3 + x + 1.
    static function logic [GfWidth-1:0] field_mul(input logic [GfWidth-1:0] a,
                                                  input logic [GfWidth-1:0] b);
      logic [GfWidth-1:0] prod;
      prod = '0;
      for (int i = GfWidth - 1; i >= 0; i--) begin
        prod = {prod[GfWidth-2:0], 1'b0} ^ (prod[GfWidth-1] ? ReduceLow : '0);
        if (b[i]) begin
          prod = prod ^ a;
        end
      end
      return prod;
    endfunction

    function void set_key(input logic [GfWidth-1:0] value);
      key = value;
      key_writes++;
    endfunction

    function void note_block(input logic [GfWidth-1:0] blk, input logic last);
      // A new message starts from the key itself; a key change mid-message
      // only affects the powers formed after it.
      if (!in_message) begin
        acc = '0;
        power = key;
      end
      acc = acc ^ field_mul(blk, power);
      blocks_seen++;
      if (last) begin
        expected_hashes.push_back(acc);
        acc = '0;
        power = '0;
        in_message = 1'b0;
        messages_seen++;
      end else begin
        power = field_mul(power, key);
        in_message = 1'b1;
      end
    endfunction

    function void check_hash(input logic [GfWidth-1:0] actual);
      logic [GfWidth-1:0] want;
      if (expected_hashes.size() == 0) begin
        errors++;
        $display("%0t: hash mismatch: expected none, actual %h", $time, actual);
        return;
      end
      want = expected_hashes.pop_front();
      hashes_checked++;
      if (actual !== want) begin
        errors++;
        $display("%0t: hash mismatch: expected %h, actual %h", $time, want, actual);
      end
    endfunction

    function int unsigned pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [GfWidth-1:0] message_block_i = '0;
  logic               final_block_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [GfWidth-1:0] hash_value_o;
  logic               hash_key_we_i = 1'b0;
  logic [GfWidth-1:0] hash_key_i = '0;

  hash_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  bit             hold_go = 1'b0;
  int unsigned    hold_count = 0;
  int unsigned    cycle_count = 0;

  gf2_64_polynomial_eval_hash dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_block_i(message_block_i),
    .final_block_i  (final_block_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o),
    .hash_key_we_i  (hash_key_we_i),
    .hash_key_i     (hash_key_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      sb.check_hash(hash_value_o);
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_go && hold_count < HoldCycles) begin
        hold_count++;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [GfWidth-1:0] random_block();
    logic [GfWidth-1:0] one_hot;
    one_hot = TopBit >> $urandom_range(GfWidth - 1);
    case ($urandom_range(15))
      0: return '0;
      1: return AllOnes;
      2: return one_hot;
      3: return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [GfWidth-1:0] pick_key();
    case ($urandom_range(9))
      0: return '0;
      1: return 64'h1;
      2: return AllOnes;
      3: return TopBit;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_length();
    if ($urandom_range(99) < 85) begin
      return $urandom_range(6, 1);
    end
    return $urandom_range(40, 7);
  endfunction

  // Valid stays high after a transaction; the next call either replaces the
  // payload or drops valid while it idles.
  task automatic send_block(input logic [GfWidth-1:0] blk, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    message_block_i <= blk;
    final_block_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_block(blk, last);
  endtask

  task automatic send_message(input int unsigned len, input bit closed);
    for (int i = 0; i < len; i++) begin
      send_block(random_block(), closed && (i == len - 1));
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [GfWidth-1:0] value);
    @(negedge clk_i);
    hash_key_we_i <= 1'b1;
    hash_key_i <= value;
    @(posedge clk_i);
    sb.set_key(value);
    @(negedge clk_i);
    hash_key_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    // The key resets to zero, so every hash is zero.
    send_block(AllOnes, 1'b1);
    send_block({$urandom, $urandom}, 1'b0);
    send_block(AllOnes, 1'b1);
    // With a unit key the hash is the XOR of the blocks; a lone zero block is
    // how an empty message arrives.
    settle();
    write_key(64'h1);
    send_block('0, 1'b1);
    send_block(AllOnes, 1'b1);
    send_block(TopBit, 1'b0);
    send_block(64'h1, 1'b1);
    settle();
    write_key(AllOnes);
    send_block(AllOnes, 1'b1);
    send_block(TopBit, 1'b1);
    send_block({$urandom, $urandom}, 1'b0);
    send_block({$urandom, $urandom}, 1'b0);
    send_block(AllOnes, 1'b1);
    settle();
    write_key(TopBit);
    send_block(AllOnes, 1'b0);
    send_block(AllOnes, 1'b0);
    send_block(AllOnes, 1'b1);
    // Change the key in the middle of a message.
    settle();
    write_key({$urandom, $urandom});
    send_block({$urandom, $urandom}, 1'b0);
    send_block({$urandom, $urandom}, 1'b0);
    settle();
    write_key({$urandom, $urandom});
    send_block({$urandom, $urandom}, 1'b0);
    send_block({$urandom, $urandom}, 1'b1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 20;
    run_directed();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < SubPhases / 3; s++) begin
        settle();
        write_key(pick_key());
        if (p == 2 && s == 0) begin
          hold_go = 1'b1;
        end
        sent = 0;
        while (sent < RandomBlocks / SubPhases) begin
          len = pick_length();
          send_message(len, 1'b1);
          sent += len;
        end
        // At random, leave a message open so the next key write lands mid-message.
        if ($urandom_range(1) == 1) begin
          send_message($urandom_range(3, 1), 1'b0);
        end
      end
    end
    settle();

    $display("Run covered %0d blocks in %0d messages under %0d key writes; %0d hashes checked.",
             sb.blocks_seen, sb.messages_seen, sb.key_writes, sb.hashes_checked);
    $display("Sender and receiver idled in turn, and the receiver held off %0d cycles once.",
             hold_count);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/gpeh_pkg.sv
hw/rtl/gpeh_in_stage.sv
hw/rtl/gpeh_core.sv
hw/rtl/gf2_64_polynomial_eval_hash.sv
verif/gf2_64_polynomial_eval_hash_tb.sv
